@@ sv/fifo_evicting_key_set_macros.svh @@
// Assertion macros for the key set RTL.
`ifndef FIFO_EVICTING_KEY_SET_MACROS_SVH
`define FIFO_EVICTING_KEY_SET_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fes_pkg.sv @@
// Package with sizes, codes, types and helpers for the FIFO-evicting key set.
`timescale 1ns / 1ps
`default_nettype none

package fes_pkg;

  // Storage sizes.
  localparam int DEPTH  = 64;
  localparam int KEY_W  = 64;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 7;

  // Operation codes carried in the input tuser.
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  // Request from the item pipeline and configuration port to the key store.
  typedef struct packed {
    logic             add_en;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_cap;
  } store_req_t;

  // Map a written capacity onto the legal range 1..DEPTH.
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CFG_W-1:0] v);
    int unsigned vi;
    vi = int'(v);
    if (vi == 0) begin
      return CNT_W'(1);
    end
    if (vi > DEPTH) begin
      return CNT_W'(DEPTH);
    end
    return CNT_W'(vi);
  endfunction

endpackage

`default_nettype wire

@@ sv/fes_key_store.sv @@
// Key slots with parallel compare, FIFO replacement pointer and occupancy count.
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_evicting_key_set_macros.svh"

module fes_key_store (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [fes_pkg::KEY_W-1:0] key,
  input  wire fes_pkg::store_req_t      req,
  output logic                          hit
);

  // Slot storage; entries at or above the occupancy are never compared.
  logic [fes_pkg::KEY_W-1:0]  slots_r [fes_pkg::DEPTH];
  logic [fes_pkg::SLOT_W-1:0] next_r, next_nxt;
  logic [fes_pkg::CNT_W-1:0]  occ_r, occ_nxt;
  logic [fes_pkg::CNT_W-1:0]  cap_r, cap_nxt;
  logic [fes_pkg::DEPTH-1:0]  match;
  logic [fes_pkg::SLOT_W-1:0] slot_sel;
  logic [fes_pkg::CNT_W-1:0]  slot_inc;
  logic                       wr_en;

  // Compare the key against every occupied slot at once.
  always_comb begin
    for (int i = 0; i < fes_pkg::DEPTH; i++) begin
      match[i] = (slots_r[i] == key) && (fes_pkg::CNT_W'(i) < occ_r);
    end
  end

  assign hit   = |match;
  assign wr_en = req.add_en && !hit;

  // Pointer, occupancy and capacity update.
  always_comb begin
    slot_sel = (fes_pkg::CNT_W'(next_r) >= cap_r) ? '0 : next_r;
    slot_inc = fes_pkg::CNT_W'(slot_sel) + fes_pkg::CNT_W'(1);
    next_nxt = next_r;
    occ_nxt  = occ_r;
    cap_nxt  = cap_r;
    if (req.cfg_we) begin
      cap_nxt  = fes_pkg::eff_capacity(req.cfg_cap);
      next_nxt = '0;
      occ_nxt  = '0;
    end else if (wr_en) begin
      next_nxt = (slot_inc >= cap_r) ? '0 : slot_inc[fes_pkg::SLOT_W-1:0];
      if (occ_r < cap_r) begin
        occ_nxt = occ_r + fes_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r <= '0;
      occ_r  <= '0;
      cap_r  <= fes_pkg::CNT_W'(fes_pkg::DEPTH);
    end else begin
      next_r <= next_nxt;
      occ_r  <= occ_nxt;
      cap_r  <= cap_nxt;
    end
  end

  // Slot write: a new key lands in the oldest or next free slot.
  always_ff @(posedge clk) begin
    if (wr_en && !req.cfg_we) begin
      slots_r[slot_sel] <= key;
    end
  end

  `FES_ASSERT_NOW(a_occ_le_cap, clk, rst_n, 1'b1, occ_r <= cap_r, "occupancy above capacity")
  `FES_ASSERT_NOW(a_next_lt_cap, clk, rst_n, 1'b1, fes_pkg::CNT_W'(next_r) < cap_r, "slot pointer beyond capacity")
  `FES_ASSERT_NOW(a_fill_order, clk, rst_n, occ_r < cap_r, fes_pkg::CNT_W'(next_r) == occ_r, "fill pointer does not follow occupancy")
  `FES_ASSERT_NEXT(a_add_grows, clk, rst_n, wr_en && !req.cfg_we && (occ_r < cap_r), occ_r == $past(occ_r) + fes_pkg::CNT_W'(1), "new key did not raise occupancy")
  `FES_ASSERT_NEXT(a_hit_holds, clk, rst_n, req.add_en && hit && !req.cfg_we, ($stable(occ_r) && $stable(next_r)), "duplicate add changed the set")

endmodule

`default_nettype wire

@@ sv/fifo_evicting_key_set.sv @@
// Each item passes through the input register, and its result through the result register.
// Throughput: one item per cycle unless a full result register stalls; the key compare
// against all slots and the slot write both complete in the single stage between them.
// Reset (rst_n low, synchronous) empties the set and restores capacity to 64.
// A capacity write also empties the set; it is taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none

module fifo_evicting_key_set (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input items.
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [fes_pkg::KEY_W-1:0] in_tdata,   // [63:0] key
  input  wire logic                      in_tuser,   // [0] operation
  // Result items.
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [7:0]                     out_tdata,  // [0] present, [7:1] zero
  // Capacity register write.
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [fes_pkg::CFG_W-1:0] cfg_data
);

  logic                      s1_valid_r;
  logic                      s1_op_r;
  logic [fes_pkg::KEY_W-1:0] s1_key_r;
  logic                      out_valid_r;
  logic                      out_present_r;
  logic                      process;
  logic                      hit;
  fes_pkg::store_req_t       req;

  // The stage advances whenever the result register is free or being drained.
  assign process   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || process;
  assign cfg_ready = 1'b1;

  assign req.add_en  = process && (s1_op_r == fes_pkg::OP_ADD);
  assign req.cfg_we  = cfg_valid && cfg_ready;
  assign req.cfg_cap = cfg_data;

  fes_key_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (s1_key_r),
    .req   (req),
    .hit   (hit)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tuser;
      s1_key_r <= in_tdata;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (process) begin
      out_present_r <= hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_present_r};

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the FIFO-evicting key set, with a scoreboard class.
`timescale 1ns / 1ps

// Tracks the keys the block should hold and the present flags it should return.
class membership_tracker;
  logic [fes_pkg::KEY_W-1:0] stored_key [fes_pkg::DEPTH];
  int unsigned held;
  int unsigned write_slot;
  int unsigned cap_limit;
  int unsigned errors;
  logic expected_present [$];

  function new();
    held       = 0;
    write_slot = 0;
    cap_limit  = fes_pkg::DEPTH;
    errors     = 0;
  endfunction

  // A capacity write clamps the value into 1..DEPTH and empties the set.
  function void set_capacity(logic [fes_pkg::CFG_W-1:0] value);
    if (value == 0) begin
      cap_limit = 1;
    end else if (value > fes_pkg::DEPTH) begin
      cap_limit = fes_pkg::DEPTH;
    end else begin
      cap_limit = value;
    end
    held       = 0;
    write_slot = 0;
  endfunction

  // Predicts the present flag for an accepted item and applies an add.
  function void record_item(logic op, logic [fes_pkg::KEY_W-1:0] key);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < held; i++) begin
      if (stored_key[i] === key) begin
        hit = 1'b1;
      end
    end
    // A new key takes the next slot, which is the oldest one once the set is full.
    if (op == fes_pkg::OP_ADD && !hit) begin
      stored_key[write_slot] = key;
      if (held < cap_limit) begin
        held++;
      end
      write_slot = (write_slot + 1 >= cap_limit) ? 0 : write_slot + 1;
    end
    expected_present.push_back(hit);
  endfunction

  // Compares an accepted result item with the oldest expectation.
  function void check_result(logic [7:0] data);
    logic want;
    if (expected_present.size() == 0) begin
      $error("result item with no expectation waiting, present %0d", data[0]);
      errors++;
      return;
    end
    want = expected_present.pop_front();
    if (data[0] !== want) begin
      $error("present: expected %0d, actual %0d", want, data[0]);
      errors++;
    end
    if (data[7:1] !== 7'd0) begin
      $error("padding: expected %0d, actual %0d", 7'd0, data[7:1]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_present.size();
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [fes_pkg::KEY_W-1:0]     in_tdata   = '0;
  logic                          in_tuser   = fes_pkg::OP_CHECK;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [fes_pkg::CFG_W-1:0]     cfg_data   = '0;

  membership_tracker             tracker;
  logic [fes_pkg::KEY_W-1:0]     key_pool [$];
  int unsigned                   cycle_count = 0;
  rx_mode_t                      rx_mode     = RX_STEADY;
  int unsigned                   mode_left   = 0;

  fifo_evicting_key_set uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Run limit in case the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver switches between stall patterns of random duration.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_STEADY: out_tready <= 1'b1;
      RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ((cycle_count % 7) < 4);
    endcase
  end

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata);
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input logic op, input logic [fes_pkg::KEY_W-1:0] key);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    tracker.record_item(op, key);
  endtask

  task automatic idle(input int unsigned cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender until every expected result item has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the capacity register once the block is idle.
  task automatic write_capacity(input logic [fes_pkg::CFG_W-1:0] value);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    tracker.set_capacity(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from the pool, some near misses and some fully random keys.
  function automatic logic [fes_pkg::KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (sel < 90) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)]
             ^ (64'd1 << $urandom_range(0, fes_pkg::KEY_W - 1));
    end
    return {$urandom, $urandom};
  endfunction

  // One random phase: fresh key pool sized around the capacity, bursty sender.
  task automatic run_phase(input logic [fes_pkg::CFG_W-1:0] cap, input int unsigned count);
    int unsigned burst_left;
    int unsigned pool_size;
    logic        op;
    write_capacity(cap);
    pool_size = tracker.cap_limit + $urandom_range(0, tracker.cap_limit / 2 + 2);
    key_pool.delete();
    repeat (pool_size) key_pool.push_back({$urandom, $urandom});
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 4) != 0) begin
          idle($urandom_range(1, 6));
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      end
      op = ($urandom_range(0, 99) < 65) ? fes_pkg::OP_ADD : fes_pkg::OP_CHECK;
      send_item(op, pick_key());
      burst_left--;
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset capacity: empty set, duplicate add, extreme key values.
    send_item(fes_pkg::OP_CHECK, 64'h0);
    send_item(fes_pkg::OP_ADD,   64'h0);
    send_item(fes_pkg::OP_CHECK, 64'h0);
    send_item(fes_pkg::OP_ADD,   64'hFFFF_FFFF_FFFF_FFFF);
    send_item(fes_pkg::OP_ADD,   64'h0);
    send_item(fes_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(fes_pkg::OP_CHECK, 64'h5555_5555_5555_5555);
    send_item(fes_pkg::OP_ADD,   64'hAAAA_AAAA_AAAA_AAAA);

    // Capacity of one: the write empties the set and each new key evicts the last.
    write_capacity(7'd1);
    send_item(fes_pkg::OP_CHECK, 64'h0);
    send_item(fes_pkg::OP_ADD,   64'h5555_5555_5555_5555);
    send_item(fes_pkg::OP_ADD,   64'hAAAA_AAAA_AAAA_AAAA);
    send_item(fes_pkg::OP_CHECK, 64'h5555_5555_5555_5555);
    send_item(fes_pkg::OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA);

    // Capacity of zero behaves as a capacity of one.
    write_capacity(7'd0);
    send_item(fes_pkg::OP_ADD,   64'hFFFF_FFFF_FFFF_FFFF);
    send_item(fes_pkg::OP_ADD,   64'h0);
    send_item(fes_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(fes_pkg::OP_CHECK, 64'h0);

    // Capacity above the depth is held to the depth.
    write_capacity(7'd127);
    send_item(fes_pkg::OP_CHECK, 64'h0);
    send_item(fes_pkg::OP_ADD,   64'hFFFF_FFFF_FFFF_FFFF);
    send_item(fes_pkg::OP_ADD,   64'h0);
    send_item(fes_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random phases over a spread of capacities, extremes included.
    run_phase(7'd64, 150);
    run_phase(7'd2, 50);
    run_phase(7'd1, 30);
    run_phase(7'd127, 100);
    run_phase(7'd63, 60);
    run_phase(7'd0, 30);
    run_phase(fes_pkg::CFG_W'($urandom_range(3, 62)), 60);
    run_phase(7'd5, 40);
    run_phase(7'd100, 30);

    drain();
    repeat (3) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/fes_pkg.sv
sv/fes_key_store.sv
sv/fifo_evicting_key_set.sv
test/tb_top.sv
